// ----- hdl/swld_pkg.sv -----
// package for the sync word length deframer
// shared result codes, sync word constant and the step result struct
// no dependencies
`timescale 1ns / 1ps

package swld_pkg;

  localparam int unsigned SYNC_LEN = 8;
  localparam logic [63:0] SYNC_WORD = 64'h626C_7565_7374_6172;

  localparam int unsigned MAX_W = 25;
  localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 25'h100_0000;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_EMPTY   = 2'd1;
  localparam kind_t KIND_DROP    = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       last;
    kind_t      result_kind;
  } step_res_t;

endpackage

// ----- hdl/swld_core.sv -----
// frame state machine: sync hunt, header and length capture, payload count
// depends on swld_pkg; advances one byte per accepted request
`timescale 1ns / 1ps

module swld_core #(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [7:0]                data_byte,
  input  logic [swld_pkg::MAX_W-1:0] max_frame_bytes,
  output swld_pkg::step_res_t       res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SPARE   = 2'd3
  } phase_t;

  localparam logic [6:0]  HDR_CNT = 7'(HEADER_BYTES);
  localparam logic [32:0] HDR_TOT = 33'(HEADER_BYTES);
  localparam logic [6:0]  SYNC_CNT = 7'(swld_pkg::SYNC_LEN);

  phase_t                      phase_r, phase_nxt;
  logic [63:0]                 win_r, win_nxt;
  logic [6:0]                  hcnt_r, hcnt_nxt;
  logic [31:0]                 len_r, len_nxt;
  logic [swld_pkg::MAX_W-1:0]  left_r, left_nxt;

  logic [63:0] win_shift;
  logic [6:0]  hcnt_inc;
  logic [32:0] total;

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    hcnt_nxt  = hcnt_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    res       = '0;
    win_shift = {win_r[55:0], data_byte};
    hcnt_inc  = hcnt_r + 7'd1;

    // length bytes sit at header offsets 8 to 11, little endian
    if (hcnt_r == 7'd8)  len_nxt[7:0]   = len_r[7:0]   | data_byte;
    if (hcnt_r == 7'd9)  len_nxt[15:8]  = len_r[15:8]  | data_byte;
    if (hcnt_r == 7'd10) len_nxt[23:16] = len_r[23:16] | data_byte;
    if (hcnt_r == 7'd11) len_nxt[31:24] = len_r[31:24] | data_byte;
    total = HDR_TOT + {1'b0, len_nxt};

    case (phase_r)
      PH_HEADER: begin
        hcnt_nxt = hcnt_inc;
        if (hcnt_inc >= HDR_CNT) begin
          hcnt_nxt = '0;
          if (total > {8'd0, max_frame_bytes}) begin
            phase_nxt       = PH_HUNT;
            res.valid       = 1'b1;
            res.last        = 1'b1;
            res.result_kind = swld_pkg::KIND_DROP;
          end else if (len_nxt == '0) begin
            phase_nxt       = PH_HUNT;
            res.valid       = 1'b1;
            res.last        = 1'b1;
            res.result_kind = swld_pkg::KIND_EMPTY;
          end else begin
            // length fits below max, so 25 bits hold it
            left_nxt  = len_nxt[swld_pkg::MAX_W-1:0];
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          len_nxt = len_nxt;
        end
      end
      PH_PAYLOAD: begin
        res.valid        = 1'b1;
        res.payload_byte = data_byte;
        res.result_kind  = swld_pkg::KIND_PAYLOAD;
        if (left_r <= swld_pkg::MAX_W'(1)) begin
          left_nxt  = '0;
          res.last  = 1'b1;
          phase_nxt = PH_HUNT;
        end else begin
          left_nxt = left_r - swld_pkg::MAX_W'(1);
        end
      end
      default: begin
        // hunting, spare code behaves the same
        len_nxt = len_r;
        if (win_shift == swld_pkg::SYNC_WORD) begin
          win_nxt   = '0;
          phase_nxt = PH_HEADER;
          hcnt_nxt  = SYNC_CNT;
          len_nxt   = '0;
          left_nxt  = '0;
        end else begin
          win_nxt   = win_shift;
          phase_nxt = PH_HUNT;
        end
      end
    endcase
    if (!step_en) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      hcnt_r  <= '0;
      len_r   <= '0;
      left_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      hcnt_r  <= hcnt_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- hdl/sync_word_length_deframer.sv -----
// top level of the sync word length deframer: stream ports, max size register,
// output register; depends on swld_pkg and swld_core
//
//   channel  dir  payload                                   handshake
//   in_      in   tdata[7:0] data_byte                      tvalid/tready
//   out_     out  tdata[7:0] payload_byte, tlast, tuser[1:0] kind  tvalid/tready
//   cfg_     in   wr_data[24:0] max_frame_bytes             wr_en, no wait
//
// one byte per cycle while in_tready is high; a result shows in the cycle after its request is taken
// the step logic sits between the state registers and one output register
// in_tready drops only while a result waits and out_tready is low
// synchronous active-low reset: hunting, empty window, max size 16777216
`timescale 1ns / 1ps

module sync_word_length_deframer #(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] payload_byte
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser,  // [1:0] result_kind
  input  logic                        cfg_wr_en,
  input  logic [swld_pkg::MAX_W-1:0]  cfg_wr_data
);

  logic [swld_pkg::MAX_W-1:0] max_r;
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  swld_pkg::kind_t            out_kind_r;
  logic                       accept;
  swld_pkg::step_res_t        res;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  swld_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (accept),
    .data_byte       (in_tdata),
    .max_frame_bytes (max_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= swld_pkg::MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= res.payload_byte;
      out_last_r <= res.last;
      out_kind_r <= res.result_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

endmodule

// ----- hdl/swld_checker.sv -----
// port-level checks for the sync word length deframer, bound to the top level
// depends on swld_pkg and sync_word_length_deframer
`timescale 1ns / 1ps

module swld_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // non-payload results are single items with zero data
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != swld_pkg::KIND_PAYLOAD |-> out_tlast && out_tdata == 8'd0)
    else $error("bad empty or drop result");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == swld_pkg::KIND_PAYLOAD || out_tuser == swld_pkg::KIND_EMPTY
      || out_tuser == swld_pkg::KIND_DROP)
    else $error("unknown result kind");

  // input stalls only behind a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

endmodule

bind sync_word_length_deframer swld_checker u_swld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
